/* src/rpn_stack_calculator_defines.svh */
// Assertion macros shared by the calculator modules.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn: next-cycle check failed");

`endif

/* src/rpn_pkg.sv */
// Shared constants, codes and interface structs of the RPN stack calculator.
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int QUO_W   = DATA_W + FRAC_BITS;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ADD_W   = DATA_W + 2;
    localparam int CNT_W   = $clog2(QUO_W + 1);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [PROD_W-1:0] RND_ADD = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_POP   = 4'd5,
        CMD_PEEK  = 4'd6,
        CMD_SWAP  = 4'd7,
        CMD_CLEAR = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO_DIV = 3'd3,
        ST_UNKNOWN  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

endpackage

/* src/rpn_stack_calculator.sv */
// Top level: command sequencer, stack pointer, stack memory and shared ALU.
//
//  channel   handshake           payload
//  command   start / busy        i_req_type, i_operand_value
//  result    o_strobe (1 cycle)  o_status, o_result_value, o_stack_count
//
// A command is taken when start is high and busy is low; its result follows
// on o_strobe. Push, clear and unknown finish from the decode state; pop and
// peek read the top entry first, and swap reads both entries and writes them
// back. Mul and div are set by the bit-per-cycle passes of the shared 34-bit
// adder in the ALU; a short stack or a zero divisor ends sooner.
// Busy stays high for the whole command.
// Reset is synchronous and empties the stack; the receiver cannot stall.
`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [3:0]                           i_req_type,
    input  logic signed [rpn_pkg::DATA_W-1:0]    i_operand_value,
    output logic                                 o_strobe,
    output logic [2:0]                           o_status,
    output logic signed [rpn_pkg::DATA_W-1:0]    o_result_value,
    output logic [rpn_pkg::COUNT_W-1:0]          o_stack_count
);
    import rpn_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_READ_B   = 10'b0000000100,
        S_READ_A   = 10'b0000001000,
        S_ALU_GO   = 10'b0000010000,
        S_ALU_WAIT = 10'b0000100000,
        S_SHOW     = 10'b0001000000,
        S_SWAP_1   = 10'b0010000000,
        S_SWAP_2   = 10'b0100000000,
        S_SWAP_3   = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_cmd, n_cmd;
    logic [DATA_W-1:0] r_operand, n_operand;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic              r_empty, n_empty;
    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_shown, n_shown;

    logic              fin;
    t_status           fin_status;
    logic [ADDR_W-1:0] top_addr, sec_addr, push_addr;
    logic              sp_zero, sp_room;
    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rd_data;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;

    rpn_stack_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    rpn_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign top_addr  = ADDR_W'(r_sp - SP_W'(1));
    assign sec_addr  = ADDR_W'(r_sp - SP_W'(2));
    assign push_addr = ADDR_W'(r_sp);
    assign sp_zero   = (r_sp == '0);
    assign sp_room   = (r_sp < SP_W'(STACK_DEPTH));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_operand  = r_operand;
        n_sp       = r_sp;
        n_a        = r_a;
        n_b        = r_b;
        n_empty    = r_empty;
        n_status   = r_status;
        n_shown    = r_shown;
        n_strobe   = 1'b0;
        fin        = 1'b0;
        fin_status = ST_OK;
        mem_req    = '0;
        alu_req    = '0;
        alu_req.a  = r_a;
        alu_req.b  = r_b;
        unique case (r_cmd)
            CMD_SUB: alu_req.op = ALU_SUB;
            CMD_MUL: alu_req.op = ALU_MUL;
            CMD_DIV: alu_req.op = ALU_DIV;
            default: alu_req.op = ALU_ADD;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_req_type;
                    n_operand = i_operand_value;
                    n_empty   = 1'b0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_shown = '0;
                unique case (r_cmd)
                    CMD_PUSH: begin
                        fin = 1'b1;
                        if (sp_room) begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = push_addr;
                            mem_req.wr_data = r_operand;
                            n_sp            = r_sp + SP_W'(1);
                        end else begin
                            fin_status = ST_FULL;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                        if (!sp_zero) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = top_addr;
                            n_sp            = r_sp - SP_W'(1);
                            n_state         = S_READ_B;
                        end else if (r_cmd == CMD_DIV) begin
                            // zero divisor from an empty stack reports empty
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            n_a     = '0;
                            n_b     = '0;
                            n_empty = 1'b1;
                            n_state = S_ALU_GO;
                        end
                    end
                    CMD_POP: begin
                        if (sp_zero) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = top_addr;
                            n_sp            = r_sp - SP_W'(1);
                            n_state         = S_SHOW;
                        end
                    end
                    CMD_PEEK: begin
                        if (sp_zero) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = top_addr;
                            n_state         = S_SHOW;
                        end
                    end
                    CMD_SWAP: begin
                        if (r_sp < SP_W'(2)) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = top_addr;
                            n_state         = S_SWAP_1;
                        end
                    end
                    CMD_CLEAR: begin
                        fin        = 1'b1;
                        fin_status = sp_zero ? ST_EMPTY : ST_OK;
                        n_sp       = '0;
                    end
                    default: begin
                        fin        = 1'b1;
                        fin_status = ST_UNKNOWN;
                    end
                endcase
            end
            S_READ_B: begin
                n_b = mem_rd_data;
                if ((r_cmd == CMD_DIV) && (mem_rd_data == '0)) begin
                    // divisor stays popped
                    fin        = 1'b1;
                    fin_status = ST_ZERO_DIV;
                end else if (!sp_zero) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = top_addr;
                    n_sp            = r_sp - SP_W'(1);
                    n_state         = S_READ_A;
                end else begin
                    n_a     = '0;
                    n_empty = 1'b1;
                    n_state = S_ALU_GO;
                end
            end
            S_READ_A: begin
                n_a     = mem_rd_data;
                n_state = S_ALU_GO;
            end
            S_ALU_GO: begin
                alu_req.start = 1'b1;
                n_state       = S_ALU_WAIT;
            end
            S_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    fin        = 1'b1;
                    fin_status = r_empty ? ST_EMPTY : ST_OK;
                    if (sp_room) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = push_addr;
                        mem_req.wr_data = alu_rsp.result;
                        n_sp            = r_sp + SP_W'(1);
                    end
                end
            end
            S_SHOW: begin
                n_shown = mem_rd_data;
                fin     = 1'b1;
            end
            S_SWAP_1: begin
                n_b             = mem_rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = sec_addr;
                n_state         = S_SWAP_2;
            end
            S_SWAP_2: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = top_addr;
                mem_req.wr_data = mem_rd_data;
                n_state         = S_SWAP_3;
            end
            S_SWAP_3: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sec_addr;
                mem_req.wr_data = r_b;
                fin             = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            n_strobe = 1'b1;
            n_status = fin_status;
            n_state  = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_operand <= n_operand;
        r_a       <= n_a;
        r_b       <= n_b;
        r_empty   <= n_empty;
        r_status  <= n_status;
        r_shown   <= n_shown;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_value = r_shown;
    assign o_stack_count  = COUNT_W'(r_sp);

    `RPN_ASSERT_IMP(a_strobe_after_work, i_clk, i_rst_n, r_strobe, $past(r_state) != S_IDLE)
    `RPN_ASSERT_IMP(a_alu_push_fits, i_clk, i_rst_n, (r_state == S_ALU_WAIT) && alu_rsp.done,
                    r_sp < SP_W'(STACK_DEPTH))
    `RPN_ASSERT_NXT(a_transfer_sets_busy, i_clk, i_rst_n, start && !busy, busy)

endmodule

/* src/rpn_stack_mem.sv */
// Stack storage: one write port and one registered read port.
module rpn_stack_mem (
    input  logic                          i_clk,
    input  rpn_pkg::t_mem_req             i_req,
    output logic [rpn_pkg::DATA_W-1:0]    o_rd_data
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/rpn_alu.sv */
// Iterative arithmetic unit: one shared adder for add, sub, shift-add multiply
// and restoring divide, with saturation on the way out.
`include "rpn_stack_calculator_defines.svh"

module rpn_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_alu_req i_req,
    output rpn_pkg::t_alu_rsp o_rsp
);
    import rpn_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_RUN  = 3'b010,
        A_FIN  = 3'b100
    } t_alu_state;

    t_alu_state        r_state, n_state;
    t_alu_op           r_op;
    logic              r_neg;
    logic [DATA_W-1:0] r_a, r_b;
    logic [DATA_W-1:0] r_ma, r_mb;
    logic [DATA_W-1:0] r_hi, r_lo;
    logic [DATA_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [ADD_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_res;
    logic              r_done;

    logic [ADD_W-1:0]  add_x, add_y, add_sum;
    logic              add_sub;
    logic [DATA_W:0]   mul_step;
    logic              quo_bit;
    logic [DATA_W-1:0] mag_a, mag_b;
    logic [PROD_W-1:0] prod, prod_rnd, fin_mag;
    logic [DATA_W-1:0] fin_res;

    assign mag_a = i_req.a[DATA_W-1] ? (~i_req.a + DATA_W'(1)) : i_req.a;
    assign mag_b = i_req.b[DATA_W-1] ? (~i_req.b + DATA_W'(1)) : i_req.b;

    // Shared adder: operand routing depends on the operation in flight.
    always_comb begin
        unique case (r_op)
            ALU_ADD: begin
                add_x   = ADD_W'($signed(r_a));
                add_y   = ADD_W'($signed(r_b));
                add_sub = 1'b0;
            end
            ALU_SUB: begin
                add_x   = ADD_W'($signed(r_a));
                add_y   = ADD_W'($signed(r_b));
                add_sub = 1'b1;
            end
            ALU_MUL: begin
                add_x   = {2'b00, r_hi};
                add_y   = {2'b00, r_ma};
                add_sub = 1'b0;
            end
            ALU_DIV: begin
                add_x   = {1'b0, r_rem, r_quo[QUO_W-1]};
                add_y   = {2'b00, r_mb};
                add_sub = 1'b1;
            end
            default: begin
                add_x   = '0;
                add_y   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_x + (add_sub ? ~add_y : add_y) + ADD_W'(add_sub);
    end

    assign mul_step = r_lo[0] ? add_sum[DATA_W:0] : {1'b0, r_hi};
    assign quo_bit  = ~add_sum[ADD_W-1];

    // Final scaling and saturation.
    always_comb begin
        prod     = {r_hi, r_lo};
        prod_rnd = r_neg ? (prod + RND_ADD) : prod;
        fin_mag  = (r_op == ALU_MUL) ? (prod_rnd >> FRAC_BITS) : PROD_W'(r_quo);
        unique case (r_op)
            ALU_ADD, ALU_SUB: begin
                if (!r_sum[ADD_W-1] && (r_sum[ADD_W-2:DATA_W-1] != '0)) begin
                    fin_res = SAT_MAX;
                end else if (r_sum[ADD_W-1] && (r_sum[ADD_W-2:DATA_W-1] != '1)) begin
                    fin_res = SAT_MIN;
                end else begin
                    fin_res = r_sum[DATA_W-1:0];
                end
            end
            default: begin
                if (!r_neg) begin
                    fin_res = (fin_mag > PROD_W'(SAT_MAX)) ? SAT_MAX : fin_mag[DATA_W-1:0];
                end else begin
                    fin_res = (fin_mag > PROD_W'(SAT_MIN)) ? SAT_MIN
                                                           : (~fin_mag[DATA_W-1:0] + DATA_W'(1));
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE:  if (i_req.start) n_state = A_RUN;
            A_RUN:   if (r_cnt == '0) n_state = A_FIN;
            A_FIN:   n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == A_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_a   <= i_req.a;
                    r_b   <= i_req.b;
                    r_neg <= i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
                    r_ma  <= mag_a;
                    r_mb  <= mag_b;
                    r_hi  <= '0;
                    r_lo  <= mag_b;
                    r_rem <= '0;
                    r_quo <= QUO_W'(mag_a) << FRAC_BITS;
                    unique case (i_req.op)
                        ALU_MUL: r_cnt <= CNT_W'(DATA_W - 1);
                        ALU_DIV: r_cnt <= CNT_W'(QUO_W - 1);
                        default: r_cnt <= '0;
                    endcase
                end
            end
            A_RUN: begin
                r_cnt <= r_cnt - CNT_W'(1);
                unique case (r_op)
                    ALU_MUL: begin
                        // shift the partial product right one bit per step
                        r_hi <= mul_step[DATA_W:1];
                        r_lo <= {mul_step[0], r_lo[DATA_W-1:1]};
                    end
                    ALU_DIV: begin
                        r_rem <= quo_bit ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
                        r_quo <= {r_quo[QUO_W-2:0], quo_bit};
                    end
                    default: r_sum <= add_sum;
                endcase
            end
            A_FIN:   r_res <= fin_res;
            default: ;
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    `RPN_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_req.start, r_state == A_IDLE)
    `RPN_ASSERT_NXT(a_fin_gives_done, i_clk, i_rst_n, r_state == A_FIN, r_done)

endmodule
